FILE: design/bkjq_pkg.sv
`default_nettype none

package bkjq_pkg;

  // Store size; index math wraps modulo DEPTH, so it stays a power of two
  localparam int unsigned DEPTH = 64;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  // order_mode codes
  localparam logic [1:0] MODE_FIFO = 2'd0;
  localparam logic [1:0] MODE_LIFO = 2'd1;
  localparam logic [1:0] MODE_PRIO = 2'd2;

  // status codes
  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [15:0]        job_handle;
    logic signed [31:0] bound_key;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [15:0]        popped_handle;
    logic signed [31:0] popped_key;
    logic [15:0]        min_handle;
    logic signed [31:0] min_key;
    logic [15:0]        max_handle;
    logic signed [31:0] max_key;
    logic [6:0]         entry_count;
    logic               is_empty;
  } res_t;

  typedef struct packed {
    logic [15:0]        handle;
    logic signed [31:0] key;
  } entry_t;

endpackage

`default_nettype wire

FILE: design/bound_keyed_job_queue.sv
`default_nettype none

// Bound-keyed job queue: holds up to 64 jobs (16-bit handle, signed Q16.16
// key) in a circular buffer memory, slot 0 of the logical order at head.
// Command channel: a word is taken when start is high and busy is low;
// busy stays high through the result strobe. Result channel: done_o is high
// for exactly one cycle with result_o valid; the receiver cannot stall it.
// Config channel: cfg_data_i (order_mode) is written when cfg_valid_i and
// cfg_ready_o are high; write it only while the block is idle.
// The single-read-port memory sets the pace: the search for the insert
// point, the one-step-per-cycle shift and the min/max scan each read one
// entry per cycle; the search and the scan share one signed comparator pair.
// A new command may be taken in the cycle after done_o.
// Reset clears the count, head pointer, order_mode (FIFO) and the
// sequencer; the memory is not cleared, entries beyond the count are
// never read.

module bound_keyed_job_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire bkjq_pkg::req_t req_i,
  output logic               done_o,
  output bkjq_pkg::res_t     result_o,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [1:0]    cfg_data_i
);
  import bkjq_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_POP_RD = 7'b0000010,
    ST_SEARCH = 7'b0000100,
    ST_SHIFT  = 7'b0001000,
    ST_INSERT = 7'b0010000,
    ST_SCAN   = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [1:0]    order_mode_q;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] pos_q, pos_d;
  logic          rd_stop_q, rd_stop_d;

  // latched command word
  req_t req_q;

  // result fields
  logic [1:0]         status_q, status_d;
  logic [15:0]        pop_h_q, pop_h_d;
  logic signed [31:0] pop_k_q, pop_k_d;
  logic [15:0]        min_h_q, min_h_d;
  logic signed [31:0] min_k_q, min_k_d;
  logic [15:0]        max_h_q, max_h_d;
  logic signed [31:0] max_k_q, max_k_d;

  // memory and its ports
  entry_t        mem_q [DEPTH];
  logic          rd_en;
  logic [CW-1:0] rd_idx;
  entry_t        rdata_q;
  logic [CW-1:0] ridx_q;
  logic          rvalid_q;
  logic          wr_en;
  logic [AW-1:0] wr_phys;
  entry_t        wdata;

  // shared comparators on the read word
  logic signed [31:0] lt_ref;
  logic               rd_lt;
  logic               rd_gt;
  logic [CW-1:0]      last_idx;

  entry_t new_entry;

  assign new_entry.handle = req_q.job_handle;
  assign new_entry.key    = req_q.bound_key;
  assign last_idx         = count_q - CW'(1);

  assign lt_ref = (state_q == ST_SEARCH) ? req_q.bound_key : min_k_q;
  assign rd_lt  = rdata_q.key < lt_ref;
  assign rd_gt  = rdata_q.key > max_k_q;

  // memory: one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_phys] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem_q[head_q + rd_idx[AW-1:0]];
      ridx_q  <= rd_idx;
    end
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    count_d   = count_q;
    idx_d     = idx_q;
    pos_d     = pos_q;
    rd_stop_d = rd_stop_q;
    status_d  = status_q;
    pop_h_d   = pop_h_q;
    pop_k_d   = pop_k_q;
    min_h_d   = min_h_q;
    min_k_d   = min_k_q;
    max_h_d   = max_h_q;
    max_k_d   = max_k_q;
    rd_en     = 1'b0;
    rd_idx    = idx_q;
    wr_en     = 1'b0;
    wr_phys   = head_q + count_q[AW-1:0];
    wdata     = new_entry;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          status_d = STATUS_DONE;
          pop_h_d  = '0;
          pop_k_d  = '0;
          idx_d    = '0;
          if (req_i.operation == OP_PUSH && count_q == CW'(DEPTH)) begin
            status_d = STATUS_FULL;
            state_d  = ST_SCAN;
          end else if (req_i.operation == OP_POP && count_q == '0) begin
            status_d = STATUS_EMPTY;
            state_d  = ST_SCAN;
          end else if (req_i.operation == OP_POP) begin
            rd_en   = 1'b1;
            rd_idx  = '0;
            state_d = ST_POP_RD;
          end else if (order_mode_q == MODE_LIFO) begin
            wr_en   = 1'b1;
            wr_phys = head_q - AW'(1);
            wdata.handle = req_i.job_handle;
            wdata.key    = req_i.bound_key;
            head_d  = head_q - AW'(1);
            count_d = count_q + CW'(1);
            state_d = ST_SCAN;
          end else if (order_mode_q == MODE_PRIO && count_q != '0) begin
            pos_d   = count_q;
            state_d = ST_SEARCH;
          end else begin
            // back of the store (FIFO, unused mode, or empty priority store)
            wr_en   = 1'b1;
            wdata.handle = req_i.job_handle;
            wdata.key    = req_i.bound_key;
            count_d = count_q + CW'(1);
            state_d = ST_SCAN;
          end
        end
      end

      ST_POP_RD: begin
        pop_h_d = rdata_q.handle;
        pop_k_d = rdata_q.key;
        head_d  = head_q + AW'(1);
        count_d = count_q - CW'(1);
        idx_d   = '0;
        state_d = ST_SCAN;
      end

      // find the first entry whose key is below the new key
      ST_SEARCH: begin
        if (rvalid_q && rd_lt) begin
          pos_d     = ridx_q;
          idx_d     = last_idx;
          rd_stop_d = 1'b0;
          state_d   = ST_SHIFT;
        end else if (rvalid_q && ridx_q == last_idx) begin
          pos_d   = count_q;
          state_d = ST_INSERT;
        end else if (idx_q < count_q) begin
          rd_en = 1'b1;
          idx_d = idx_q + CW'(1);
        end
      end

      // move entries pos..count-1 one slot back, last one first
      ST_SHIFT: begin
        if (!rd_stop_q) begin
          rd_en = 1'b1;
          if (idx_q == pos_q) begin
            rd_stop_d = 1'b1;
          end else begin
            idx_d = idx_q - CW'(1);
          end
        end
        if (rvalid_q) begin
          wr_en   = 1'b1;
          wr_phys = head_q + ridx_q[AW-1:0] + AW'(1);
          wdata   = rdata_q;
          if (ridx_q == pos_q) begin
            state_d = ST_INSERT;
          end
        end
      end

      ST_INSERT: begin
        wr_en   = 1'b1;
        wr_phys = head_q + pos_q[AW-1:0];
        count_d = count_q + CW'(1);
        idx_d   = '0;
        state_d = ST_SCAN;
      end

      // min / max over the held entries, front to back
      ST_SCAN: begin
        if (count_q == '0) begin
          min_h_d = '0;
          min_k_d = '0;
          max_h_d = '0;
          max_k_d = '0;
          state_d = ST_DONE;
        end else begin
          if (rvalid_q) begin
            if (ridx_q == '0) begin
              min_h_d = rdata_q.handle;
              min_k_d = rdata_q.key;
              max_h_d = rdata_q.handle;
              max_k_d = rdata_q.key;
            end else begin
              if (rd_lt) begin
                min_h_d = rdata_q.handle;
                min_k_d = rdata_q.key;
              end
              if (rd_gt) begin
                max_h_d = rdata_q.handle;
                max_k_d = rdata_q.key;
              end
            end
            if (ridx_q == last_idx) begin
              state_d = ST_DONE;
            end
          end
          if (idx_q < count_q) begin
            rd_en = 1'b1;
            idx_d = idx_q + CW'(1);
          end
        end
      end

      ST_DONE: begin
        state_d = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      order_mode_q <= MODE_FIFO;
      head_q       <= '0;
      count_q      <= '0;
      idx_q        <= '0;
      pos_q        <= '0;
      rd_stop_q    <= 1'b0;
      rvalid_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      count_q   <= count_d;
      idx_q     <= idx_d;
      pos_q     <= pos_d;
      rd_stop_q <= rd_stop_d;
      rvalid_q  <= rd_en;
      if (cfg_valid_i && cfg_ready_o) begin
        order_mode_q <= cfg_data_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start) begin
      req_q <= req_i;
    end
    status_q <= status_d;
    pop_h_q  <= pop_h_d;
    pop_k_q  <= pop_k_d;
    min_h_q  <= min_h_d;
    min_k_q  <= min_k_d;
    max_h_q  <= max_h_d;
    max_k_q  <= max_k_d;
  end

  // outputs
  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign done_o      = (state_q == ST_DONE);

  assign result_o.status        = status_q;
  assign result_o.popped_handle = pop_h_q;
  assign result_o.popped_key    = pop_k_q;
  assign result_o.min_handle    = min_h_q;
  assign result_o.min_key       = min_k_q;
  assign result_o.max_handle    = max_h_q;
  assign result_o.max_key       = max_k_q;
  assign result_o.entry_count   = 7'(count_q);
  assign result_o.is_empty      = (count_q == '0);

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
`default_nettype none

module tb_top;
  import bkjq_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned RAND_WORDS  = 1800;

  // One line of the directed plan: a mode write or a command word
  typedef enum logic {ROW_CMD, ROW_CFG} row_kind_e;
  typedef struct {
    row_kind_e  kind;
    logic [1:0] mode;
    req_t       cmd;
    bit         typed;
    res_t       want;
  } plan_row_t;

  logic       clk_i;
  logic       rst_ni    = 1'b0;
  logic       start     = 1'b0;
  req_t       cmd_req   = '0;
  logic       cfg_valid = 1'b0;
  logic [1:0] cfg_data  = '0;
  logic       busy;
  logic       done_o;
  res_t       result_o;
  logic       cfg_ready_o;

  // Shadow of the job store and of order_mode
  entry_t     job_q[$];
  logic [1:0] order_sel = MODE_FIFO;

  res_t       pending_results[$];
  plan_row_t  plan[$];

  int unsigned cycle_cnt   = 0;
  int unsigned errors      = 0;
  int unsigned sent        = 0;
  int unsigned n_checked   = 0;
  int unsigned n_push      = 0;
  int unsigned n_pop       = 0;
  int unsigned n_full_push = 0;
  int unsigned n_empty_pop = 0;
  int unsigned cfg_writes  = 0;
  bit [3:0]    modes_used  = '0;
  bit          no_idle     = 1'b0;

  bound_keyed_job_queue dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (cmd_req),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop if the block hangs
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("%0t: cycle limit hit, %0d results still due", $time, pending_results.size());
    $display("end of test: mismatches");
    $finish;
  end

  // Applies one command to the shadow store and returns the expected result word
  function automatic res_t apply_job_op(input req_t r);
    res_t        res;
    entry_t      e;
    int unsigned pos;
    bit          found;
    res = '0;
    res.status = STATUS_DONE;
    if (r.operation == OP_PUSH) begin
      if (job_q.size() >= DEPTH) begin
        res.status = STATUS_FULL;
      end else begin
        e.handle = r.job_handle;
        e.key    = r.bound_key;
        pos      = job_q.size();
        if (order_sel == MODE_LIFO) begin
          pos = 0;
        end else if (order_sel == MODE_PRIO) begin
          // land before the first strictly smaller key
          found = 1'b0;
          for (int i = 0; i < job_q.size(); i++) begin
            if (!found && $signed(job_q[i].key) < $signed(e.key)) begin
              pos   = i;
              found = 1'b1;
            end
          end
        end
        job_q.insert(pos, e);
      end
    end else begin
      if (job_q.size() == 0) begin
        res.status = STATUS_EMPTY;
      end else begin
        e = job_q[0];
        job_q.delete(0);
        res.popped_handle = e.handle;
        res.popped_key    = e.key;
      end
    end
    // min/max scan from the front, first hit keeps a tie
    if (job_q.size() > 0) begin
      res.min_handle = job_q[0].handle;
      res.min_key    = job_q[0].key;
      res.max_handle = job_q[0].handle;
      res.max_key    = job_q[0].key;
      for (int i = 1; i < job_q.size(); i++) begin
        if ($signed(job_q[i].key) < $signed(res.min_key)) begin
          res.min_key    = job_q[i].key;
          res.min_handle = job_q[i].handle;
        end
        if ($signed(res.max_key) < $signed(job_q[i].key)) begin
          res.max_key    = job_q[i].key;
          res.max_handle = job_q[i].handle;
        end
      end
    end
    res.entry_count = 7'(job_q.size());
    res.is_empty    = (job_q.size() == 0);
    return res;
  endfunction

  function automatic res_t mk_res(input logic [1:0] st, input logic [15:0] ph,
                                  input logic [31:0] pk, input logic [15:0] mnh,
                                  input logic [31:0] mnk, input logic [15:0] mxh,
                                  input logic [31:0] mxk, input logic [6:0] cnt);
    res_t r;
    r.status        = st;
    r.popped_handle = ph;
    r.popped_key    = pk;
    r.min_handle    = mnh;
    r.min_key       = mnk;
    r.max_handle    = mxh;
    r.max_key       = mxk;
    r.entry_count   = cnt;
    r.is_empty      = (cnt == 0);
    return r;
  endfunction

  function automatic req_t mk_req(input logic op, input logic [15:0] h, input logic [31:0] k);
    req_t r;
    r.operation  = op;
    r.job_handle = h;
    r.bound_key  = k;
    return r;
  endfunction

  function automatic int pick_gap();
    if (no_idle || $urandom_range(0, 99) >= 21) return 0;
    if ($urandom_range(0, 3) == 0) return $urandom_range(9, 40);
    return $urandom_range(1, 8);
  endfunction

  // Key styles: 0 any pattern, 1 extremes and round values, 2 a few close values (ties)
  function automatic logic [31:0] pick_key(input int style);
    logic [31:0] k;
    k = $urandom;
    case (style)
      1: begin
        case ($urandom_range(0, 4))
          0: k = 32'h8000_0000;
          1: k = 32'h7FFF_FFFF;
          2: k = '0;
          3: k = '1;
          default: k = {16'($urandom_range(0, 3)), 16'h0000};
        endcase
      end
      2: k = 32'($urandom_range(0, 6)) - 32'd3;
      default: ;
    endcase
    return k;
  endfunction

  function automatic logic [15:0] pick_handle();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic add_cmd(input logic op, input logic [15:0] h, input logic [31:0] k);
    plan_row_t row;
    row.kind  = ROW_CMD;
    row.mode  = '0;
    row.cmd   = mk_req(op, h, k);
    row.typed = 1'b0;
    row.want  = '0;
    plan.insert(plan.size(), row);
  endtask

  task automatic add_typed(input logic op, input logic [15:0] h, input logic [31:0] k,
                           input res_t want);
    plan_row_t row;
    row.kind  = ROW_CMD;
    row.mode  = '0;
    row.cmd   = mk_req(op, h, k);
    row.typed = 1'b1;
    row.want  = want;
    plan.insert(plan.size(), row);
  endtask

  task automatic add_cfg(input logic [1:0] m);
    plan_row_t row;
    row.kind  = ROW_CFG;
    row.mode  = m;
    row.cmd   = '0;
    row.typed = 1'b0;
    row.want  = '0;
    plan.insert(plan.size(), row);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Sends one command word; the expectation is logged at the accepting edge
  task automatic issue_cmd(input req_t r, input bit typed, input res_t want);
    int   gap;
    res_t predicted;
    gap = pick_gap();
    repeat (gap) @(negedge clk_i);
    @(negedge clk_i);
    start   <= 1'b1;
    cmd_req <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predicted = apply_job_op(r);
    pending_results.insert(pending_results.size(), typed ? want : predicted);
    sent++;
    if (r.operation == OP_PUSH) n_push++;
    else n_pop++;
    if (predicted.status == STATUS_FULL) n_full_push++;
    if (predicted.status == STATUS_EMPTY) n_empty_pop++;
    @(negedge clk_i);
    start <= 1'b0;
  endtask

  // Mode writes only once every result is back
  task automatic write_mode(input logic [1:0] m);
    int gap;
    wait_drained();
    gap = pick_gap();
    repeat (gap) @(negedge clk_i);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    order_sel = m;
    cfg_writes++;
    modes_used[m] = 1'b1;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %h got %h", $time, name, want, got);
    end
  endtask

  // Result checker: one word per strobe against the oldest expectation
  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, got %h", $time, result_o);
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        n_checked++;
        check_field("status", 32'(want.status), 32'(result_o.status));
        check_field("popped_handle", 32'(want.popped_handle), 32'(result_o.popped_handle));
        check_field("popped_key", want.popped_key, result_o.popped_key);
        check_field("min_handle", 32'(want.min_handle), 32'(result_o.min_handle));
        check_field("min_key", want.min_key, result_o.min_key);
        check_field("max_handle", 32'(want.max_handle), 32'(result_o.max_handle));
        check_field("max_key", want.max_key, result_o.max_key);
        check_field("entry_count", 32'(want.entry_count), 32'(result_o.entry_count));
        check_field("is_empty", 32'(want.is_empty), 32'(result_o.is_empty));
      end
    end
  end

  initial begin : stimulus
    int          phase_no;
    int          phase_len;
    int          push_pct;
    int          key_style;
    bit          hold_mid;
    logic [31:0] k;

    // Directed plan: extremes, empty pops, every mode, ties, mode swaps with jobs held
    add_typed(OP_POP, 16'h0000, 32'h0, mk_res(STATUS_EMPTY, 0, 0, 0, 0, 0, 0, 0));
    add_typed(OP_PUSH, 16'hFFFF, 32'h7FFF_FFFF,
              mk_res(STATUS_DONE, 0, 0, 16'hFFFF, 32'h7FFF_FFFF, 16'hFFFF, 32'h7FFF_FFFF, 1));
    add_typed(OP_PUSH, 16'h0000, 32'h8000_0000,
              mk_res(STATUS_DONE, 0, 0, 16'h0000, 32'h8000_0000, 16'hFFFF, 32'h7FFF_FFFF, 2));
    add_cmd(OP_PUSH, 16'h1234, 32'h0);
    add_typed(OP_POP, 16'hFFFF, 32'hFFFF_FFFF,
              mk_res(STATUS_DONE, 16'hFFFF, 32'h7FFF_FFFF, 16'h0000, 32'h8000_0000,
                     16'h1234, 32'h0, 2));
    add_cmd(OP_POP, 16'h0000, 32'h0);
    add_typed(OP_POP, 16'h0000, 32'h0, mk_res(STATUS_DONE, 16'h1234, 0, 0, 0, 0, 0, 0));
    add_typed(OP_POP, 16'h5555, 32'h5555_5555, mk_res(STATUS_EMPTY, 0, 0, 0, 0, 0, 0, 0));
    add_cfg(MODE_LIFO);
    add_cmd(OP_PUSH, 16'h00A1, 32'h000A_0000);
    add_cmd(OP_PUSH, 16'h00B2, 32'h000A_0000);
    add_cmd(OP_PUSH, 16'h00C3, 32'hFFFF_0000);
    add_cmd(OP_POP, 16'h0000, 32'h0);
    // priority on top of a LIFO-ordered store
    add_cfg(MODE_PRIO);
    add_cmd(OP_PUSH, 16'h00D4, 32'h0005_0000);
    add_cmd(OP_PUSH, 16'h00E5, 32'h000A_0000);
    add_cmd(OP_PUSH, 16'h00F6, 32'h7FFF_FFFF);
    add_cmd(OP_PUSH, 16'h0107, 32'h8000_0000);
    add_cmd(OP_POP, 16'h0000, 32'h0);
    add_cmd(OP_POP, 16'h0000, 32'h0);
    // unused code falls back to FIFO
    add_cfg(2'd3);
    add_cmd(OP_PUSH, 16'h0218, 32'h0003_0000);
    add_cmd(OP_POP, 16'h0000, 32'h0);
    add_cfg(MODE_FIFO);
    add_cmd(OP_POP, 16'h0000, 32'h0);
    add_cmd(OP_POP, 16'h0000, 32'h0);
    add_cmd(OP_POP, 16'h0000, 32'h0);

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) write_mode(plan[i].mode);
      else issue_cmd(plan[i].cmd, plan[i].typed, plan[i].want);
    end

    // Random phases: each picks a push/pop mix and a key style, most a mode too
    phase_no = 0;
    while (sent < RAND_WORDS + plan.size()) begin
      if (phase_no < 4) write_mode(2'(phase_no));
      else if ($urandom_range(0, 99) < 60) write_mode(2'($urandom_range(0, 3)));
      case ($urandom_range(0, 2))
        0: push_pct = 15;
        1: push_pct = 50;
        default: push_pct = 88;
      endcase
      key_style = $urandom_range(0, 2);
      phase_len = $urandom_range(20, 140);
      no_idle   = 1'b0;
      if (phase_no == 2) begin
        // long back-to-back stretch that fills the store
        phase_len = 300;
        push_pct  = 75;
        no_idle   = 1'b1;
      end
      hold_mid = ($urandom_range(0, 2) == 0);
      for (int n = 0; n < phase_len; n++) begin
        if (hold_mid && n == phase_len / 2) wait_drained();
        k = pick_key(key_style);
        if ($urandom_range(0, 99) < push_pct) begin
          issue_cmd(mk_req(OP_PUSH, pick_handle(), k), 1'b0, '0);
        end else begin
          // pop fields are don't-care but still toggled
          issue_cmd(mk_req(OP_POP, pick_handle(), k), 1'b0, '0);
        end
      end
      phase_no++;
    end
    no_idle = 1'b0;

    wait_drained();
    repeat (220) @(posedge clk_i);
    if (pending_results.size() != 0) errors++;

    $display("Ran %0d commands (%0d pushes, %0d pops), checked %0d results.",
             sent, n_push, n_pop, n_checked);
    $display("Refused: %0d pushes on full, %0d pops on empty; %0d mode writes, modes %b.",
             n_full_push, n_empty_pop, cfg_writes, modes_used);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
